// File: rtl/pedal_plausibility_check_unit_assert.svh
// ----------------------------------------------------------------------------
// pedal plausibility check assertion macros
// shared assertion forms for the pedal plausibility check unit
// ----------------------------------------------------------------------------
`ifndef PEDAL_PLAUSIBILITY_CHECK_UNIT_ASSERT_SVH
`define PEDAL_PLAUSIBILITY_CHECK_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define PPC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define PPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// shared types and codes of the pedal plausibility check unit
// ----------------------------------------------------------------------------
package ppc_pkg;

	// sensor selector for the shared divider
	localparam logic [1:0] SEL_ACC_ONE = 2'd0;
	localparam logic [1:0] SEL_ACC_TWO = 2'd1;
	localparam logic [1:0] SEL_BRAKE   = 2'd2;

	// calibration register indexes
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_ACC_ONE_START = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ACC_ONE_END   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ACC_TWO_START = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_ACC_TWO_END   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_BRAKE_START   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_BRAKE_END     = 3'd5;

	// fault cause codes
	localparam logic [1:0] CAUSE_NONE     = 2'd0;
	localparam logic [1:0] CAUSE_WINDOW   = 2'd1;
	localparam logic [1:0] CAUSE_MISMATCH = 2'd2;
	localparam logic [1:0] CAUSE_BRAKE    = 2'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic       load;    // capture the input transaction
		logic       init;    // set up the divider for the selected sensor
		logic       step;    // one restoring division step
		logic       store;   // write the normalized value of the selected sensor
		logic       finish;  // evaluate the rules, update latch and result
		logic [1:0] sel;
	} ppc_cmd_t;

endpackage

// File: rtl/ppc_ctrl.sv
// ----------------------------------------------------------------------------
// ppc_ctrl
// sequencer: three divisions on the shared divider, then rule evaluation
// ----------------------------------------------------------------------------
module ppc_ctrl #(
	parameter int STEPS = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output ppc_pkg::ppc_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_INIT   = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_STORE  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	localparam int CNT_W = $clog2(STEPS);

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       sel_q, sel_d;
	logic             out_valid_q;
	logic             finish;

	assign finish = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		sel_d      = sel_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.sel    = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					sel_d    = ppc_pkg::SEL_ACC_ONE;
					state_d  = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				cnt_d    = '0;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					state_d = ST_STORE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				if (sel_q == ppc_pkg::SEL_BRAKE) begin
					state_d = ST_FINISH;
				end else begin
					sel_d   = sel_q + 1'b1;
					state_d = ST_INIT;
				end
			end
			ST_FINISH: begin
				if (finish) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sel_q       <= ppc_pkg::SEL_ACC_ONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/ppc_dp.sv
// ----------------------------------------------------------------------------
// ppc_dp
// datapath: calibration registers, shared restoring divider, rule logic
// ----------------------------------------------------------------------------
module ppc_dp #(
	parameter int ADC_BITS      = 12,
	parameter int WINDOW_MARGIN = 20,
	parameter int FRAC_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ppc_pkg::ppc_cmd_t             cmd,
	input  logic [ADC_BITS-1:0]           acc_one_raw,
	input  logic [ADC_BITS-1:0]           acc_two_raw,
	input  logic [ADC_BITS-1:0]           brake_raw,
	input  logic                          cfg_we,
	input  logic [ppc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [ADC_BITS-1:0]           cfg_data,
	output logic [FRAC_BITS:0]            throttle,
	output logic signed [FRAC_BITS+2:0]   brake_level,
	output logic                          latched,
	output logic [1:0]                    fault_cause
);

	localparam int AW = ADC_BITS;
	localparam int SW = ADC_BITS + 1;
	localparam int QW = FRAC_BITS + 2;
	localparam int NW = FRAC_BITS + 3;
	localparam int ONE_Q        = 1 << FRAC_BITS;
	localparam int SAT_Q        = 2 * ONE_Q;
	localparam int TH_MISMATCH  = (ONE_Q + 5) / 10;
	localparam int TH_BRAKE_ON  = (2 * ONE_Q + 5) / 10;
	localparam int TH_ACC_LOW   = (ONE_Q + 10) / 20;
	localparam int TH_BRAKE_OFF = (3 * ONE_Q + 10) / 20;

	// calibration registers
	logic [AW-1:0] a1s_q, a1e_q, a2s_q, a2e_q, bs_q, be_q;
	// captured readings
	logic [AW-1:0] r1_q, r2_q, rb_q;
	// divider
	logic [AW-1:0] rem_q, den_q;
	logic [QW-1:0] sh_q, quo_q;
	logic          neg_q, sat_q, zero_q;
	// normalized values
	logic signed [NW-1:0] n1_q, n2_q, nb_q;
	// result
	logic [FRAC_BITS:0] thr_q;
	logic [1:0]         cause_q;
	logic               latch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1s_q <= '0;
			a1e_q <= '1;
			a2s_q <= '0;
			a2e_q <= '1;
			bs_q  <= '0;
			be_q  <= '1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ppc_pkg::REG_ACC_ONE_START: a1s_q <= cfg_data;
				ppc_pkg::REG_ACC_ONE_END:   a1e_q <= cfg_data;
				ppc_pkg::REG_ACC_TWO_START: a2s_q <= cfg_data;
				ppc_pkg::REG_ACC_TWO_END:   a2e_q <= cfg_data;
				ppc_pkg::REG_BRAKE_START:   bs_q  <= cfg_data;
				ppc_pkg::REG_BRAKE_END:     be_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand selection and divider setup
	logic [AW-1:0]        raw_sel, start_sel, end_sel;
	logic signed [SW-1:0] diff_s, span_s;
	logic [AW-1:0]        mag, den;
	logic                 sat_pre;

	always_comb begin
		case (cmd.sel)
			ppc_pkg::SEL_ACC_ONE: begin
				raw_sel = r1_q; start_sel = a1s_q; end_sel = a1e_q;
			end
			ppc_pkg::SEL_ACC_TWO: begin
				raw_sel = r2_q; start_sel = a2s_q; end_sel = a2e_q;
			end
			default: begin
				raw_sel = rb_q; start_sel = bs_q; end_sel = be_q;
			end
		endcase
	end

	assign diff_s  = $signed({1'b0, raw_sel}) - $signed({1'b0, start_sel});
	assign span_s  = $signed({1'b0, end_sel}) - $signed({1'b0, start_sel});
	assign mag     = diff_s[SW-1] ? AW'(-diff_s) : diff_s[AW-1:0];
	assign den     = span_s[SW-1] ? AW'(-span_s) : span_s[AW-1:0];
	// quotient of four or more saturates anyway
	assign sat_pre = {2'b00, mag} >= {den, 2'b00};

	// one restoring step
	logic [AW:0] trial;
	logic        qbit;
	assign trial = {rem_q, sh_q[QW-1]};
	assign qbit  = trial >= {1'b0, den_q};

	// quotient to signed normalized value
	logic [QW-1:0]        qmag;
	logic signed [NW-1:0] nval;
	always_comb begin
		if (zero_q) begin
			qmag = '0;
		end else if (sat_q || quo_q > QW'(SAT_Q)) begin
			qmag = QW'(SAT_Q);
		end else begin
			qmag = quo_q;
		end
		nval = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r1_q <= acc_one_raw;
			r2_q <= acc_two_raw;
			rb_q <= brake_raw;
		end
		if (cmd.init) begin
			rem_q  <= mag >> 2;
			sh_q   <= {mag[1:0], {FRAC_BITS{1'b0}}};
			den_q  <= den;
			quo_q  <= '0;
			neg_q  <= diff_s[SW-1] ^ span_s[SW-1];
			sat_q  <= sat_pre;
			zero_q <= (span_s == '0);
		end else if (cmd.step) begin
			rem_q <= qbit ? AW'(trial - {1'b0, den_q}) : trial[AW-1:0];
			sh_q  <= sh_q << 1;
			quo_q <= {quo_q[QW-2:0], qbit};
		end
		if (cmd.store) begin
			case (cmd.sel)
				ppc_pkg::SEL_ACC_ONE: n1_q <= nval;
				ppc_pkg::SEL_ACC_TWO: n2_q <= nval;
				default:              nb_q <= nval;
			endcase
		end
	end

	// window checks against the calibration span widened by the margin
	logic [AW:0] margin;
	logic [AW-1:0] lo1, hi1, lo2, hi2;
	logic out1, out2, out_win;
	assign margin = (AW+1)'(WINDOW_MARGIN);
	assign lo1 = (a1s_q < a1e_q) ? a1s_q : a1e_q;
	assign hi1 = (a1s_q < a1e_q) ? a1e_q : a1s_q;
	assign lo2 = (a2s_q < a2e_q) ? a2s_q : a2e_q;
	assign hi2 = (a2s_q < a2e_q) ? a2e_q : a2s_q;
	assign out1 = ({1'b0, r1_q} + margin < {1'b0, lo1}) || ({1'b0, r1_q} > {1'b0, hi1} + margin);
	assign out2 = ({1'b0, r2_q} + margin < {1'b0, lo2}) || ({1'b0, r2_q} > {1'b0, hi2} + margin);
	assign out_win = out1 || out2;

	// mismatch, average and brake rules
	logic signed [NW:0] ndiff, nsum;
	logic [NW:0]        adiff;
	logic [NW-1:0]      half;
	logic [FRAC_BITS:0] thr_avg, thr_d;
	logic               mismatch, brake_on, conflict, release_ok, latch_d;
	logic [1:0]         cause_d;

	always_comb begin
		ndiff    = $signed({n1_q[NW-1], n1_q}) - $signed({n2_q[NW-1], n2_q});
		adiff    = ndiff[NW] ? (NW+1)'(-ndiff) : ndiff;
		mismatch = adiff > (NW+1)'(TH_MISMATCH);
		nsum     = $signed({n1_q[NW-1], n1_q}) + $signed({n2_q[NW-1], n2_q});
		half     = nsum[NW:1];
		if (nsum[NW] || nsum == '0) begin
			thr_avg = '0;
		end else if (half > NW'(ONE_Q)) begin
			thr_avg = (FRAC_BITS+1)'(ONE_Q);
		end else begin
			thr_avg = half[FRAC_BITS:0];
		end
		brake_on   = nb_q > $signed(NW'(TH_BRAKE_ON));
		conflict   = brake_on && (thr_avg > (FRAC_BITS+1)'(TH_ACC_LOW));
		release_ok = (thr_avg < (FRAC_BITS+1)'(TH_ACC_LOW))
			&& (nb_q < $signed(NW'(TH_BRAKE_OFF)));
		thr_d   = '0;
		latch_d = 1'b1;
		if (out_win) begin
			cause_d = ppc_pkg::CAUSE_WINDOW;
		end else if (mismatch) begin
			cause_d = ppc_pkg::CAUSE_MISMATCH;
		end else begin
			cause_d = conflict ? ppc_pkg::CAUSE_BRAKE : ppc_pkg::CAUSE_NONE;
			latch_d = (latch_q || conflict) && !release_ok;
			thr_d   = latch_d ? '0 : thr_avg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 1'b0;
		end else if (cmd.finish) begin
			latch_q <= latch_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			thr_q       <= thr_d;
			cause_q     <= cause_d;
			brake_level <= nb_q;
		end
	end

	assign throttle    = thr_q;
	assign latched     = latch_q;
	assign fault_cause = cause_q;

endmodule

// File: rtl/pedal_plausibility_check_unit.sv
// ----------------------------------------------------------------------------
// pedal_plausibility_check_unit
// dual accelerator sensor plausibility check with brake override
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one transaction per sample: both accelerator readings and
//   the brake reading. m_axis returns one result per sample: granted throttle
//   and normalized brake in tdata, latch and fault cause in tuser.
//   the cfg channel writes the six calibration counts by index; it is always
//   ready and must only be used while no sample is in flight.
// timing
//   each reading is normalized on one shared restoring divider, one quotient
//   bit per cycle, FRAC_BITS+2 steps plus setup and store per sensor. a new
//   sample is taken only once the sequencer is back in idle, which it enters
//   when the previous result is written into the output register.
// reset
//   arst_n clears the latch, restores the default calibration (start 0, end
//   full scale) and drops m_axis_tvalid; s_axis_tready comes up high.
// back-pressure
//   the result sits in an output register; a new sample is accepted while it
//   waits, but the next result is held back until m_axis_tready takes it.
// ----------------------------------------------------------------------------
`include "pedal_plausibility_check_unit_assert.svh"

module pedal_plausibility_check_unit #(
	parameter int ADC_BITS      = 12,
	parameter int WINDOW_MARGIN = 20,
	parameter int FRAC_BITS     = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input samples
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// acc_one_raw, acc_two_raw, brake_raw, zero pad
	input  logic [((3*ADC_BITS+7)/8)*8-1:0]         s_axis_tdata,
	// results
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// throttle, brake_level, zero pad
	output logic [((2*FRAC_BITS+4+7)/8)*8-1:0]      m_axis_tdata,
	// latched, fault_cause
	output logic [2:0]                             m_axis_tuser,
	// calibration writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ppc_pkg::CFG_ADDR_W-1:0]          cfg_addr,
	input  logic [ADC_BITS-1:0]                    cfg_data
);

	localparam int OUT_TW = ((2*FRAC_BITS+4+7)/8)*8;

	ppc_pkg::ppc_cmd_t cmd;

	logic [FRAC_BITS:0]          throttle;
	logic signed [FRAC_BITS+2:0] brake_level;
	logic                        latched;
	logic [1:0]                  fault_cause;

	// sequencer: owns the handshakes and walks the divider through the sensors
	ppc_ctrl #(
		.STEPS (FRAC_BITS + 2)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// datapath: calibration, divider, rules and the result register
	ppc_dp #(
		.ADC_BITS      (ADC_BITS),
		.WINDOW_MARGIN (WINDOW_MARGIN),
		.FRAC_BITS     (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.acc_one_raw (s_axis_tdata[ADC_BITS-1:0]),
		.acc_two_raw (s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
		.brake_raw   (s_axis_tdata[3*ADC_BITS-1:2*ADC_BITS]),
		.cfg_we      (cfg_valid),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.throttle    (throttle),
		.brake_level (brake_level),
		.latched     (latched),
		.fault_cause (fault_cause)
	);

	// calibration registers take a write in any cycle
	assign cfg_ready = 1'b1;

	// pack the result, unused upper bits read zero
	assign m_axis_tdata = OUT_TW'({brake_level, throttle});
	assign m_axis_tuser = {fault_cause, latched};

	// granted throttle never coexists with the latch
	`PPC_ASSERT_IMPL(a_thr_unlatched,
		m_axis_tvalid && m_axis_tdata[FRAC_BITS:0] != '0,
		!m_axis_tuser[0], "throttle granted while latched")

	// window and mismatch faults always latch and block throttle
	`PPC_ASSERT_IMPL(a_fault_blocks,
		m_axis_tvalid && (m_axis_tuser[2:1] == ppc_pkg::CAUSE_WINDOW
			|| m_axis_tuser[2:1] == ppc_pkg::CAUSE_MISMATCH),
		m_axis_tuser[0] && m_axis_tdata[FRAC_BITS:0] == '0, "sensor fault without block")

	// throttle is clamped to full travel
	`PPC_ASSERT_IMPL(a_thr_clamp,
		m_axis_tvalid && m_axis_tdata[FRAC_BITS],
		m_axis_tdata[FRAC_BITS-1:0] == '0, "throttle above full travel")

	// one sample at a time through the divider
	`PPC_ASSERT_NEXT(a_one_in_flight,
		s_axis_tvalid && s_axis_tready,
		!s_axis_tready, "second sample taken while busy")

endmodule

// File: dv/pedal_plausibility_check_unit_tb.sv
// ----------------------------------------------------------------------------
// pedal_plausibility_check_unit_tb
// self-checking bench: a directed table walk followed by random samples
// under several calibrations, with idle and back-pressure on both streams.
// outputs are compared field by field with a typed row's own expectation or
// a predictor keeping its own copy of calibration and implausibility latch.
// ----------------------------------------------------------------------------
module pedal_plausibility_check_unit_tb;
	import ppc_pkg::*;

	localparam int ADC_BITS  = 12;
	localparam int FRAC_BITS = 16;
	localparam int MARGIN    = 20;
	localparam int IN_W      = ((3*ADC_BITS+7)/8)*8;
	localparam int OUT_W     = ((2*FRAC_BITS+4+7)/8)*8;

	// fixed-point limits and thresholds, rounded to nearest
	localparam longint ONE_Q         = longint'(1) << FRAC_BITS;
	localparam longint SAT_Q         = 2 * ONE_Q;
	localparam longint TH_MISMATCH   = (ONE_Q + 5) / 10;
	localparam longint TH_BRAKE_ON   = (2 * ONE_Q + 5) / 10;
	localparam longint TH_ACC_LOW    = (ONE_Q + 10) / 20;
	localparam longint TH_BRAKE_OFF  = (3 * ONE_Q + 10) / 20;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 80;
	localparam int DIR_COUNT   = 24;
	localparam int PHASE_COUNT = 6;

	typedef struct packed {
		logic [16:0]        throttle;
		logic signed [18:0] brake_level;
		logic               latched;
		logic [1:0]         cause;
	} pedal_result_t;

	// one row of the directed table; typed rows carry their own expectation
	typedef struct packed {
		logic [1:0]    cal_set;
		logic [11:0]   acc_one;
		logic [11:0]   acc_two;
		logic [11:0]   brake;
		logic          typed;
		pedal_result_t want;
	} dir_row_t;

	typedef enum logic [1:0] {
		CAL_RANDOM,
		CAL_FULL_CROSS,
		CAL_DEGENERATE
	} cal_mode_e;

	typedef struct packed {
		cal_mode_e   mode;
		int unsigned count;
		int unsigned send_idle;
		int unsigned recv_stall;
		int unsigned hold;
	} phase_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic [2:0]            m_axis_tuser;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
	logic [ADC_BITS-1:0]   cfg_data      = '0;

	// predictor state: calibration copy and latch
	bit [11:0]     cal_q [6] = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095};
	bit            latch_q = 1'b0;
	pedal_result_t pending_results [$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_pending   = 0;
	int unsigned fail_count     = 0;
	int unsigned cycle_count    = 0;

	// calibration sets of the directed part: reset values, a window set with
	// an inverted sensor and a one-count brake span, and a degenerate set
	bit [11:0] dir_cal [3][6] = '{
		'{12'd0,    12'd4095, 12'd0,    12'd4095, 12'd0,    12'd4095},
		'{12'd1000, 12'd3000, 12'd3000, 12'd1000, 12'd2000, 12'd2001},
		'{12'd500,  12'd500,  12'd500,  12'd500,  12'd4095, 12'd0}
	};

	dir_row_t dir_rows [DIR_COUNT] = '{
		// reset calibration: zero and full travel, brake conflict, hold, release
		'{2'd0, 12'd0,    12'd0,    12'd0,    1'b1, '{17'd0,     19'sd0,     1'b0, CAUSE_NONE}},
		'{2'd0, 12'd4095, 12'd4095, 12'd0,    1'b1, '{17'd65536, 19'sd0,     1'b0, CAUSE_NONE}},
		'{2'd0, 12'd4095, 12'd4095, 12'd4095, 1'b1, '{17'd0,     19'sd65536, 1'b1, CAUSE_BRAKE}},
		'{2'd0, 12'd4095, 12'd4095, 12'd0,    1'b1, '{17'd0,     19'sd0,     1'b1, CAUSE_NONE}},
		'{2'd0, 12'd0,    12'd0,    12'd0,    1'b1, '{17'd0,     19'sd0,     1'b0, CAUSE_NONE}},
		'{2'd0, 12'd4095, 12'd0,    12'd0,    1'b1, '{17'd0,     19'sd0,     1'b1, CAUSE_MISMATCH}},
		'{2'd0, 12'd0,    12'd0,    12'd0,    1'b1, '{17'd0,     19'sd0,     1'b0, CAUSE_NONE}},
		'{2'd0, 12'd2048, 12'd2048, 12'd2048, 1'b0, '0},
		// brake still pressed with no throttle keeps the latch
		'{2'd0, 12'd0,    12'd0,    12'd4095, 1'b1, '{17'd0,     19'sd65536, 1'b1, CAUSE_NONE}},
		'{2'd0, 12'd0,    12'd0,    12'd0,    1'b1, '{17'd0,     19'sd0,     1'b0, CAUSE_NONE}},
		// just below and just above the mismatch threshold
		'{2'd0, 12'd409,  12'd0,    12'd0,    1'b0, '0},
		'{2'd0, 12'd410,  12'd0,    12'd0,    1'b0, '0},
		// window edges, both sides, both sensors; window beats mismatch
		'{2'd1, 12'd979,  12'd2000, 12'd0,    1'b0, '0},
		'{2'd1, 12'd980,  12'd3020, 12'd0,    1'b0, '0},
		'{2'd1, 12'd3021, 12'd2000, 12'd0,    1'b0, '0},
		'{2'd1, 12'd2000, 12'd3021, 12'd0,    1'b0, '0},
		'{2'd1, 12'd979,  12'd1000, 12'd0,    1'b0, '0},
		// brake saturates to plus and minus two
		'{2'd1, 12'd2000, 12'd2000, 12'd2021, 1'b0, '0},
		'{2'd1, 12'd2000, 12'd2000, 12'd0,    1'b0, '0},
		'{2'd1, 12'd1000, 12'd3000, 12'd2000, 1'b0, '0},
		// equal calibration points and an inverted full-scale brake
		'{2'd2, 12'd500,  12'd500,  12'd0,    1'b0, '0},
		'{2'd2, 12'd480,  12'd520,  12'd4095, 1'b0, '0},
		'{2'd2, 12'd479,  12'd500,  12'd4095, 1'b0, '0},
		'{2'd2, 12'd500,  12'd521,  12'd0,    1'b0, '0}
	};

	phase_t phases [PHASE_COUNT] = '{
		'{CAL_RANDOM,     100, 0,  0,  0},
		'{CAL_RANDOM,     100, 68, 0,  0},
		'{CAL_RANDOM,     100, 0,  68, 500},
		'{CAL_FULL_CROSS, 100, 37, 37, 0},
		'{CAL_DEGENERATE, 60,  37, 37, 0},
		'{CAL_RANDOM,     120, 0,  0,  0}
	};

	pedal_plausibility_check_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// global watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// (raw - start) / (end - start) in Q16, truncated toward zero, saturated
	function automatic longint normalize_q16(bit [11:0] raw, bit [11:0] start_pt,
			bit [11:0] end_pt);
		longint diff, span, quot;
		diff = longint'(raw) - longint'(start_pt);
		span = longint'(end_pt) - longint'(start_pt);
		if (span == 0)
			return 0;
		quot = ((diff < 0 ? -diff : diff) << FRAC_BITS) / (span < 0 ? -span : span);
		if (quot > SAT_Q)
			quot = SAT_Q;
		return ((diff < 0) != (span < 0)) ? -quot : quot;
	endfunction

	function automatic bit outside_window(bit [11:0] raw, bit [11:0] pt_a, bit [11:0] pt_b);
		longint lo, hi;
		lo = longint'(pt_a < pt_b ? pt_a : pt_b) - MARGIN;
		hi = longint'(pt_a < pt_b ? pt_b : pt_a) + MARGIN;
		return longint'(raw) < lo || longint'(raw) > hi;
	endfunction

	// grants throttle for one sample and advances the latch
	function automatic pedal_result_t predict_result(bit [11:0] acc_one, bit [11:0] acc_two,
			bit [11:0] brake);
		longint n1, n2, nb, gap, sum, thr;
		pedal_result_t res;
		n1  = normalize_q16(acc_one, cal_q[REG_ACC_ONE_START], cal_q[REG_ACC_ONE_END]);
		n2  = normalize_q16(acc_two, cal_q[REG_ACC_TWO_START], cal_q[REG_ACC_TWO_END]);
		nb  = normalize_q16(brake, cal_q[REG_BRAKE_START], cal_q[REG_BRAKE_END]);
		gap = n1 - n2;
		if (gap < 0)
			gap = -gap;
		thr = 0;
		res.cause = CAUSE_NONE;
		if (outside_window(acc_one, cal_q[REG_ACC_ONE_START], cal_q[REG_ACC_ONE_END]) ||
				outside_window(acc_two, cal_q[REG_ACC_TWO_START], cal_q[REG_ACC_TWO_END])) begin
			latch_q = 1'b1;
			res.cause = CAUSE_WINDOW;
		end else if (gap > TH_MISMATCH) begin
			latch_q = 1'b1;
			res.cause = CAUSE_MISMATCH;
		end else begin
			sum = n1 + n2;
			thr = (sum <= 0) ? 0 : sum / 2;
			if (thr > ONE_Q)
				thr = ONE_Q;
			if (nb > TH_BRAKE_ON && thr > TH_ACC_LOW) begin
				latch_q = 1'b1;
				res.cause = CAUSE_BRAKE;
			end
			// recovery needs pedal and brake both released
			if (thr < TH_ACC_LOW && nb < TH_BRAKE_OFF)
				latch_q = 1'b0;
			if (latch_q)
				thr = 0;
		end
		res.throttle    = thr[16:0];
		res.brake_level = nb[18:0];
		res.latched     = latch_q;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		fail_count++;
	endtask

	// drive one sample, wait for its transaction, then queue the expected result
	task automatic send_sample(input bit [11:0] acc_one, input bit [11:0] acc_two,
			input bit [11:0] brake, input bit typed, input pedal_result_t want);
		pedal_result_t expected_res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_W-36){1'b0}}, brake, acc_two, acc_one};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		expected_res = predict_result(acc_one, acc_two, brake);
		pending_results.push_back(typed ? want : expected_res);
	endtask

	// all six registers back to back, valid held high across them
	task automatic write_cal_set(input bit [11:0] vals [6]);
		for (int i = REG_ACC_ONE_START; i <= REG_BRAKE_END; i++) begin
			cfg_valid <= 1'b1;
			cfg_addr  <= CFG_ADDR_W'(i);
			cfg_data  <= vals[i];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			cal_q[i] = vals[i];
		end
		cfg_valid <= 1'b0;
	endtask

	// calibration only changes once every sample in flight has come back
	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic void pick_cal(input cal_mode_e mode, output bit [11:0] vals [6]);
		bit [11:0] lo_pt, hi_pt;
		case (mode)
			CAL_FULL_CROSS: begin
				vals = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd0};
			end
			CAL_DEGENERATE: begin
				// flat accelerator spans, brake span of three counts saturates easily
				vals = '{12'd2048, 12'd2048, 12'd4095, 12'd4095, 12'd2000, 12'd2003};
			end
			default: begin
				for (int s = 0; s < 3; s++) begin
					lo_pt = 12'($urandom_range(0, 1500));
					hi_pt = 12'($urandom_range(2500, 4095));
					if ($urandom_range(3) == 0) begin
						vals[2*s]   = hi_pt;
						vals[2*s+1] = lo_pt;
					end else begin
						vals[2*s]   = lo_pt;
						vals[2*s+1] = hi_pt;
					end
				end
			end
		endcase
	endfunction

	function automatic bit [11:0] clamp_adc(longint v);
		return (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : 12'(v);
	endfunction

	// raw count at a Q16 fraction of travel along a calibration pair
	function automatic longint travel_to_raw(longint frac, bit [11:0] start_pt, bit [11:0] end_pt);
		return longint'(start_pt) + (frac * (longint'(end_pt) - longint'(start_pt))) / ONE_Q;
	endfunction

	// mostly consistent sensor pairs, some mismatched, out of window, or pure noise
	function automatic void make_sample(output bit [11:0] acc_one, output bit [11:0] acc_two,
			output bit [11:0] brake);
		longint pedal, brake_frac, r2;
		int unsigned pick;
		pick  = $urandom_range(99);
		pedal = $urandom_range(1) ? $urandom_range(6000) : $urandom_range(68000);
		case ($urandom_range(2))
			0: brake_frac = $urandom_range(9000);
			1: brake_frac = $urandom_range(9000, 20000);
			default: brake_frac = $urandom_range(20000, 140000);
		endcase
		acc_one = clamp_adc(travel_to_raw(pedal, cal_q[REG_ACC_ONE_START], cal_q[REG_ACC_ONE_END]));
		r2      = travel_to_raw(pedal, cal_q[REG_ACC_TWO_START], cal_q[REG_ACC_TWO_END]);
		brake   = clamp_adc(travel_to_raw(brake_frac, cal_q[REG_BRAKE_START], cal_q[REG_BRAKE_END]));
		if (pick < 70) begin
			acc_two = clamp_adc(r2 + longint'($urandom_range(6)) - 3);
		end else if (pick < 80) begin
			acc_two = clamp_adc($urandom_range(1) ? r2 + $urandom_range(150, 600)
				: r2 - $urandom_range(150, 600));
		end else if (pick < 88) begin
			acc_two = clamp_adc(r2);
			if ($urandom_range(1))
				acc_one = clamp_adc(longint'(cal_q[REG_ACC_ONE_START] < cal_q[REG_ACC_ONE_END]
					? cal_q[REG_ACC_ONE_START] : cal_q[REG_ACC_ONE_END]) - MARGIN - 1
					- $urandom_range(200));
			else
				acc_two = clamp_adc(longint'(cal_q[REG_ACC_TWO_START] > cal_q[REG_ACC_TWO_END]
					? cal_q[REG_ACC_TWO_START] : cal_q[REG_ACC_TWO_END]) + MARGIN + 1
					+ $urandom_range(200));
		end else begin
			acc_one = 12'($urandom());
			acc_two = 12'($urandom());
			brake   = 12'($urandom());
		end
	endfunction

	// result side: check each output transaction, then pick the next ready.
	// a long hold-off is counted down here so the block backs up into its input
	initial begin
		pedal_result_t got, want;
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
				got.throttle    = m_axis_tdata[16:0];
				got.brake_level = m_axis_tdata[35:17];
				got.latched     = m_axis_tuser[0];
				got.cause       = m_axis_tuser[2:1];
				if (pending_results.size() == 0) begin
					report_mismatch("result transaction with nothing expected");
				end else begin
					want = pending_results.pop_front();
					if (got.throttle !== want.throttle)
						report_mismatch($sformatf("throttle %0d, expected %0d",
							got.throttle, want.throttle));
					if (got.brake_level !== want.brake_level)
						report_mismatch($sformatf("brake_level %0d, expected %0d",
							got.brake_level, want.brake_level));
					if (got.latched !== want.latched)
						report_mismatch($sformatf("latched %0b, expected %0b",
							got.latched, want.latched));
					if (got.cause !== want.cause)
						report_mismatch($sformatf("fault_cause %0d, expected %0d",
							got.cause, want.cause));
				end
			end
			if (hold_pending != 0) begin
				hold_left    = hold_pending;
				hold_pending = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// stimulus: reset, directed table, random phases, then drain and verdict
	initial begin
		bit [11:0] cal_vals [6];
		bit [11:0] acc_one, acc_two, brake;
		int unsigned cur_set;
		cur_set = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, calibration switched only between drained groups
		for (int r = 0; r < DIR_COUNT; r++) begin
			if (dir_rows[r].cal_set != cur_set) begin
				s_axis_tvalid <= 1'b0;
				drain_results();
				cur_set = dir_rows[r].cal_set;
				write_cal_set(dir_cal[cur_set]);
			end
			send_sample(dir_rows[r].acc_one, dir_rows[r].acc_two, dir_rows[r].brake,
				dir_rows[r].typed, dir_rows[r].want);
		end
		s_axis_tvalid <= 1'b0;

		// random phases, each with its own calibration and idle pattern
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain_results();
			pick_cal(phases[p].mode, cal_vals);
			write_cal_set(cal_vals);
			send_idle_pct  = phases[p].send_idle;
			recv_stall_pct = phases[p].recv_stall;
			hold_pending   = phases[p].hold;
			for (int n = 0; n < phases[p].count; n++) begin
				make_sample(acc_one, acc_two, brake);
				send_sample(acc_one, acc_two, brake, 1'b0, '0);
			end
			s_axis_tvalid <= 1'b0;
		end

		recv_stall_pct = 0;
		drain_results();
		// watch for stray results past the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
